// ===== src/rrmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmm_pkg
// Shared types and constants for the row-range matrix multiply block.
// ----------------------------------------------------------------------------
package rrmm_pkg;

    // Field widths fixed by the stream format
    localparam int IDX_W = 3;
    localparam int VAL_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W = 35;
    localparam int DIM_W = 4;

    // Stream packing
    localparam int S_DATA_W = 24;   // row, col, value = 22 bits, padded
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;   // row, col, sum = 41 bits, padded
    localparam int M_PAD_W = M_DATA_W - (2 * IDX_W + SUM_W);

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_WR_A = 2'd0;
    localparam logic [1:0] KIND_WR_B = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_BEGIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_END = 2'd2;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // Queue status seen by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/row_range_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_range_matrix_multiply
// Square matrix multiply over a configurable row range, with A and B loaded
// entry by entry and the product streamed out in row-major order.
// ----------------------------------------------------------------------------
// Usage: load every A and B entry inside matrix_dim (tuser = 0 for A, 1 for B,
// row and column in tdata), then send a start transaction (tuser = 2). Each
// load and each start passes through a four-deep command queue and is taken by
// the back end while it is idle. A start then produces one result per column
// for each row from row_begin to row_end (clipped to matrix_dim - 1), the
// final one flagged with tlast; an empty range gives nothing. Each result is
// built with one multiply-accumulate per cycle, fed by a single read port on
// each store, through read, multiply and accumulate stages, and a new result
// starts only once the output register has been taken. Loads keep being
// queued while a run is in progress.
module row_range_matrix_multiply
    import rrmm_pkg::*;
#(
    parameter int DIM_MAX = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // row_index[2:0], col_index[5:3],
                                                  // entry_value[21:6]
    input  logic [S_USER_W-1:0]   s_axis_tuser,   // kind[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // out_row[2:0], out_col[5:3],
                                                  // product_sum[40:6]
    output logic                  m_axis_tlast    // last
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_cmd_in;
    t_cmd      w_cmd_out;
    t_q_status w_q_status;

    rrmm_front #(
        .DIM_MAX(DIM_MAX)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    rrmm_cmd_fifo u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_out),
        .o_status (w_q_status)
    );

    rrmm_back #(
        .DIM_MAX(DIM_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd_out),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/rrmm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmm_front
// Input side: takes stream transactions, drops ones with no effect and
// queues store writes and start commands for the back end.
// ----------------------------------------------------------------------------
module rrmm_front
    import rrmm_pkg::*;
#(
    parameter int DIM_MAX = 8
) (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // row[2:0], col[5:3], value[21:6]
    input  logic [S_USER_W-1:0] s_axis_tuser,   // kind[1:0]
    input  t_q_status           i_q_status,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic w_accept;
    logic w_in_range;

    assign s_axis_tready = !i_q_status.full;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Unpack the transaction
    assign o_cmd.kind = s_axis_tuser;
    assign o_cmd.row = s_axis_tdata[IDX_W-1:0];
    assign o_cmd.col = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign o_cmd.value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    // Writes outside the store are dropped
    assign w_in_range = (int'(o_cmd.row) < DIM_MAX) && (int'(o_cmd.col) < DIM_MAX);

    // Classify: only in-range writes and starts go to the queue
    always_comb begin
        o_push = 1'b0;
        if (w_accept) begin
            unique case (s_axis_tuser)
                KIND_WR_A, KIND_WR_B: o_push = w_in_range;
                KIND_START:           o_push = 1'b1;
                default:              o_push = 1'b0;
            endcase
        end
    end

endmodule

// ===== src/rrmm_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmm_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rrmm_cmd_fifo
    import rrmm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_status.full = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop = i_pop && !o_status.empty;
    assign o_cmd = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/rrmm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmm_back
// Execution side: holds the A and B stores and the configuration, and runs
// the multiply-accumulate sequencer that walks the requested rows.
// ----------------------------------------------------------------------------
module rrmm_back
    import rrmm_pkg::*;
#(
    parameter int DIM_MAX = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  t_cmd                  i_cmd,
    input  t_q_status             i_q_status,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // row[2:0], col[5:3], sum[40:6]
    output logic                  m_axis_tlast
);

    localparam int DEPTH = DIM_MAX * DIM_MAX;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ENTRY = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    // Configuration
    logic [DIM_W-1:0] r_cfg_dim;
    logic [IDX_W-1:0] r_cfg_row_begin;
    logic [IDX_W-1:0] r_cfg_row_end;

    // Sequencer
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_j, n_j;
    logic [DIM_W-1:0] r_dim, n_dim;
    logic [IDX_W-1:0] r_last_row, n_last_row;
    logic             w_issue;
    logic             w_wr_a;
    logic             w_wr_b;
    logic             w_j_last;
    logic             w_k_last;
    logic             w_done;
    logic [DIM_W-1:0] w_dim_eff;
    logic [IDX_W-1:0] w_last_row;

    // Stores
    logic signed [VAL_W-1:0] r_mem_a [DEPTH];
    logic signed [VAL_W-1:0] r_mem_b [DEPTH];
    logic [AW-1:0]           w_waddr;
    logic [AW-1:0]           w_raddr_a;
    logic [AW-1:0]           w_raddr_b;
    logic signed [VAL_W-1:0] r_a_q;
    logic signed [VAL_W-1:0] r_b_q;

    // MAC pipeline
    logic                     r_v1, r_v2;
    logic                     r_first1, r_first2;
    logic                     r_lastj1, r_lastj2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  w_sum;

    // Output register
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row;
    logic [IDX_W-1:0]        r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    // Configuration writes; an unknown index does nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dim <= DIM_W'(DIM_MAX);
            r_cfg_row_begin <= '0;
            r_cfg_row_end <= 3'd7;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DIM:       r_cfg_dim <= i_cfg_data;
                CFG_ROW_BEGIN: r_cfg_row_begin <= i_cfg_data[IDX_W-1:0];
                CFG_ROW_END:   r_cfg_row_end <= i_cfg_data[IDX_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective size and clipped last row
    always_comb begin
        priority if (r_cfg_dim == '0) begin
            w_dim_eff = DIM_W'(1);
        end else if (int'(r_cfg_dim) > DIM_MAX) begin
            w_dim_eff = DIM_W'(DIM_MAX);
        end else begin
            w_dim_eff = r_cfg_dim;
        end
        if ({1'b0, r_cfg_row_end} > (w_dim_eff - 1'b1)) begin
            w_last_row = IDX_W'(w_dim_eff - 1'b1);
        end else begin
            w_last_row = r_cfg_row_end;
        end
    end

    assign w_j_last = ({1'b0, r_j} == (r_dim - 1'b1));
    assign w_k_last = ({1'b0, r_k} == (r_dim - 1'b1));
    assign w_done = r_v2 && r_lastj2;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_k = r_k;
        n_j = r_j;
        n_dim = r_dim;
        n_last_row = r_last_row;
        o_pop = 1'b0;
        w_issue = 1'b0;
        w_wr_a = 1'b0;
        w_wr_b = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        KIND_WR_A: w_wr_a = 1'b1;
                        KIND_WR_B: w_wr_b = 1'b1;
                        KIND_START: begin
                            n_dim = w_dim_eff;
                            n_last_row = w_last_row;
                            n_i = r_cfg_row_begin;
                            n_k = '0;
                            if (r_cfg_row_begin <= w_last_row) begin
                                n_state = ST_ENTRY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ENTRY: begin
                // Start a new entry only once the output register is free
                if (!r_out_valid) begin
                    n_j = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                w_issue = 1'b1;
                n_j = r_j + 1'b1;
                if (w_j_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_done) begin
                    priority if (!w_k_last) begin
                        n_k = r_k + 1'b1;
                        n_state = ST_ENTRY;
                    end else if (r_i == r_last_row) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_k = '0;
                        n_state = ST_ENTRY;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_k <= n_k;
        r_j <= n_j;
        r_dim <= n_dim;
        r_last_row <= n_last_row;
    end

    // Store addresses: write from the queue head, read A[i][j] and B[j][k]
    assign w_waddr = AW'(int'(i_cmd.row) * DIM_MAX + int'(i_cmd.col));
    assign w_raddr_a = AW'(int'(r_i) * DIM_MAX + int'(r_j));
    assign w_raddr_b = AW'(int'(r_j) * DIM_MAX + int'(r_k));

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[w_waddr] <= i_cmd.value;
        end
        r_a_q <= r_mem_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_b) begin
            r_mem_b[w_waddr] <= i_cmd.value;
        end
        r_b_q <= r_mem_b[w_raddr_b];
    end

    // MAC pipeline: read, multiply, accumulate
    assign w_sum = r_first2 ? SUM_W'(r_prod) : (r_acc + SUM_W'(r_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
        r_first1 <= (r_j == '0);
        r_lastj1 <= w_j_last;
        r_first2 <= r_first1;
        r_lastj2 <= r_lastj1;
        r_prod <= r_a_q * r_b_q;
        if (r_v2) begin
            r_acc <= w_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_row <= r_i;
            r_out_col <= r_k;
            r_out_sum <= w_sum;
            r_out_last <= w_k_last && (r_i == r_last_row);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, r_out_sum, r_out_col, r_out_row};
    assign m_axis_tlast = r_out_last;

endmodule

// ===== src/rrmm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmm_checker
// Port-level checks on the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
module rrmm_checker
    import rrmm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // A stalled result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // Each result needs a full run of multiply-accumulates, so results never come back to back
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result followed a transaction too soon");

    // Handshake outputs are driven to a known level out of reset; tready is checked only while tvalid is high
    a_ctrl_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(m_axis_tvalid) && (!s_axis_tvalid || !$isunknown(s_axis_tready)))
        else $error("handshake output unknown");

    // Padding bits of the result word stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_DATA_W-1:2*IDX_W+SUM_W] == '0))
        else $error("result padding not zero");

endmodule

bind row_range_matrix_multiply rrmm_checker u_rrmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
